// ----- src/assert_macros.svh -----
// Assertion macros shared by the countdown timer RTL.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH
`ifndef SYNTHESIS
// Check that a property holds at every clock edge outside reset.
`define KCT_ASSERT(lbl, prop, msg) \
   lbl: assert property (@(posedge clock) disable iff (reset) prop) \
      else $error(msg);
// Check that a condition never occurs outside reset.
`define KCT_NEVER(lbl, expr, msg) \
   lbl: assert property (@(posedge clock) disable iff (reset) !(expr)) \
      else $error(msg);
`else
`define KCT_ASSERT(lbl, prop, msg)
`define KCT_NEVER(lbl, expr, msg)
`endif
`endif

// ----- src/kct_pkg.sv -----
// Types, constants and key decoding for the keypad countdown timer.
package kct_pkg;

   localparam int TIME_W = 10;
   localparam int MIN_W = 4;
   localparam int SEC_W = 6;
   localparam int CURSOR_W = 2;
   localparam int KEY_W = 4;

   // Division by sixty as a multiply by a scaled reciprocal, exact below 1024
   localparam int SECS_PER_MIN = 60;
   localparam int SECS_PER_TEN = 10;
   localparam int RECIP_60 = 1093;
   localparam int RECIP_W = 11;
   localparam int RECIP_SHIFT = 16;
   localparam int QUOT_W = 5;

   typedef enum logic [1:0] {
      MODE_OFF   = 2'd0,
      MODE_ENTER = 2'd1,
      MODE_RUN   = 2'd2
   } mode_type;

   typedef enum logic {
      OP_KEY  = 1'b0,
      OP_TICK = 1'b1
   } opcode_type;

   typedef enum logic [CURSOR_W-1:0] {
      CUR_MINUTES = 2'd0,
      CUR_TENS    = 2'd1,
      CUR_UNITS   = 2'd2,
      CUR_FULL    = 2'd3
   } cursor_type;

   localparam logic [KEY_W-1:0] KEY_A = 4'd10;
   localparam logic [KEY_W-1:0] KEY_B = 4'd11;
   localparam logic [KEY_W-1:0] KEY_C = 4'd12;
   localparam logic [KEY_W-1:0] KEY_D = 4'd13;
   localparam logic [KEY_W-1:0] KEY_STAR = 4'd14;
   localparam logic [KEY_W-1:0] KEY_HASH = 4'd15;
   localparam logic [KEY_W-1:0] MAX_DIGIT = 4'd9;
   localparam logic [KEY_W-1:0] MAX_TENS = 4'd5;

   typedef struct packed {
      opcode_type  opcode;
      logic [1:0]  key_row;
      logic [1:0]  key_column;
   } req_item_type;

   typedef struct packed {
      mode_type           mode;
      logic [TIME_W-1:0]  shown;
      logic               count_up;
      logic               blink;
      logic               times_up;
   } status_type;

   // Map a keypad position to a digit value or a letter/symbol code
   function automatic logic [KEY_W-1:0] key_decode(input logic [1:0] row,
                                                   input logic [1:0] col);
      logic [KEY_W-1:0] code;
      unique case ({row, col})
         4'b00_00: code = 4'd1;
         4'b00_01: code = 4'd2;
         4'b00_10: code = 4'd3;
         4'b00_11: code = KEY_A;
         4'b01_00: code = 4'd4;
         4'b01_01: code = 4'd5;
         4'b01_10: code = 4'd6;
         4'b01_11: code = KEY_B;
         4'b10_00: code = 4'd7;
         4'b10_01: code = 4'd8;
         4'b10_10: code = 4'd9;
         4'b10_11: code = KEY_C;
         4'b11_00: code = KEY_STAR;
         4'b11_01: code = 4'd0;
         4'b11_10: code = KEY_HASH;
         4'b11_11: code = KEY_D;
         default:  code = KEY_STAR;
      endcase
      return code;
   endfunction

endpackage

// ----- src/kct_if.sv -----
// Valid/ready channel interfaces for keypad events and timer results.
interface kct_req_if;
   logic       valid;
   logic       ready;
   logic       opcode;
   logic [1:0] key_row;
   logic [1:0] key_column;

   modport source (output valid, output opcode, output key_row, output key_column,
                   input ready);
   modport sink   (input valid, input opcode, input key_row, input key_column,
                   output ready);
endinterface

interface kct_rsp_if;
   logic       valid;
   logic       ready;
   logic [1:0] mode_now;
   logic [3:0] shown_minutes;
   logic [5:0] shown_seconds;
   logic       shows_elapsed;
   logic       blink_pulse;
   logic       times_up;

   modport source (output valid, output mode_now, output shown_minutes,
                   output shown_seconds, output shows_elapsed, output blink_pulse,
                   output times_up, input ready);
   modport sink   (input valid, input mode_now, input shown_minutes,
                   input shown_seconds, input shows_elapsed, input blink_pulse,
                   input times_up, output ready);
endinterface

// ----- src/kct_req_stage.sv -----
// Input register stage: captures one keypad or tick beat.
`include "assert_macros.svh"
module kct_req_stage
   import kct_pkg::*;
(
   input  logic          clock,
   input  logic          reset,
   kct_req_if.sink       req_bus,
   input  logic          advance,
   output logic          item_valid,
   output req_item_type  item
);

   logic          valid_ff;
   logic          valid_in;
   req_item_type  item_ff;
   req_item_type  item_in;
   logic          take;

   // Accept when empty or when the held beat moves on this cycle
   assign req_bus.ready = !valid_ff || advance;
   assign take = req_bus.valid && req_bus.ready;

   // Pick the next occupancy and payload
   always_comb begin
      item_in = item_ff;
      valid_in = valid_ff;
      if (take) begin
         item_in.opcode = opcode_type'(req_bus.opcode);
         item_in.key_row = req_bus.key_row;
         item_in.key_column = req_bus.key_column;
         valid_in = 1'b1;
      end else if (advance) begin
         valid_in = 1'b0;
      end
   end

   // Hold occupancy, reset clears it
   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
      end else begin
         valid_ff <= valid_in;
      end
   end

   // Hold payload
   always_ff @(posedge clock) begin
      item_ff <= item_in;
   end

   assign item_valid = valid_ff;
   assign item = item_ff;

   `KCT_NEVER(a_adv_needs_item, advance && !valid_ff, "advance without a held beat")

endmodule

// ----- src/kct_ctrl.sv -----
// Timer state: mode, digit cursor, remaining/elapsed seconds, direction.
`include "assert_macros.svh"
module kct_ctrl
   import kct_pkg::*;
(
   input  logic          clock,
   input  logic          reset,
   input  logic          advance,
   input  req_item_type  item,
   output status_type    status
);

   mode_type            mode_ff, mode_in;
   cursor_type          cursor_ff, cursor_in;
   logic [TIME_W-1:0]   left_ff, left_in;
   logic [TIME_W-1:0]   elapsed_ff, elapsed_in;
   logic                up_ff, up_in;

   logic [KEY_W-1:0]    code;
   logic [TIME_W-1:0]   left_dec;
   logic [TIME_W-1:0]   digit_add;
   logic                digit_ok;
   logic                blink;
   logic                times_up;

   assign code = key_decode(item.key_row, item.key_column);
   assign left_dec = left_ff - TIME_W'(1);

   // Weight the digit by the cursor position
   always_comb begin
      unique case (cursor_ff)
         CUR_MINUTES: begin
            digit_add = TIME_W'(code) * TIME_W'(SECS_PER_MIN);
            digit_ok = 1'b1;
         end
         CUR_TENS: begin
            digit_add = TIME_W'(code) * TIME_W'(SECS_PER_TEN);
            digit_ok = (code <= MAX_TENS);
         end
         CUR_UNITS: begin
            digit_add = TIME_W'(code);
            digit_ok = 1'b1;
         end
         default: begin
            digit_add = '0;
            digit_ok = 1'b0;
         end
      endcase
   end

   // Work out the next state and the flags for this beat
   always_comb begin
      mode_in = mode_ff;
      cursor_in = cursor_ff;
      left_in = left_ff;
      elapsed_in = elapsed_ff;
      up_in = up_ff;
      blink = 1'b0;
      times_up = 1'b0;
      if (item.opcode == OP_TICK) begin
         if (mode_ff == MODE_RUN) begin
            left_in = left_dec;
            elapsed_in = elapsed_ff + TIME_W'(1);
            if (left_dec == '0) begin
               mode_in = MODE_OFF;
               times_up = 1'b1;
            end
         end
      end else begin
         unique case (mode_ff)
            MODE_OFF: begin
               // only D powers on; the cursor is kept
               if (code == KEY_D) begin
                  mode_in = MODE_ENTER;
                  left_in = '0;
                  elapsed_in = '0;
                  blink = 1'b1;
               end
            end
            MODE_ENTER: begin
               if (code == KEY_A) begin
                  if (left_ff != '0) begin
                     mode_in = MODE_RUN;
                     cursor_in = CUR_MINUTES;
                     blink = 1'b1;
                  end
               end else if (code == KEY_B) begin
                  mode_in = MODE_OFF;
                  cursor_in = CUR_MINUTES;
                  left_in = '0;
                  elapsed_in = '0;
               end else if (code <= MAX_DIGIT && digit_ok) begin
                  left_in = left_ff + digit_add;
                  cursor_in = cursor_type'(cursor_ff + CURSOR_W'(1));
                  blink = 1'b1;
               end
            end
            MODE_RUN: begin
               if (code == KEY_B) begin
                  mode_in = MODE_OFF;
                  cursor_in = CUR_MINUTES;
                  left_in = '0;
                  elapsed_in = '0;
               end else if (code == KEY_C) begin
                  up_in = !up_ff;
                  blink = 1'b1;
               end else if (code == KEY_D) begin
                  mode_in = MODE_ENTER;
                  left_in = '0;
                  elapsed_in = '0;
                  blink = 1'b1;
               end
            end
            default: begin
            end
         endcase
      end
   end

   // Report the state as it stands after this beat
   always_comb begin
      status.mode = mode_in;
      status.shown = up_in ? elapsed_in : left_in;
      status.count_up = up_in;
      status.blink = blink;
      status.times_up = times_up;
   end

   // Advance state only when the beat moves to the result register
   always_ff @(posedge clock) begin
      if (reset) begin
         mode_ff <= MODE_OFF;
         cursor_ff <= CUR_MINUTES;
         left_ff <= '0;
         elapsed_ff <= '0;
         up_ff <= 1'b0;
      end else if (advance) begin
         mode_ff <= mode_in;
         cursor_ff <= cursor_in;
         left_ff <= left_in;
         elapsed_ff <= elapsed_in;
         up_ff <= up_in;
      end
   end

   `KCT_ASSERT(a_run_nonzero, mode_ff == MODE_RUN |-> left_ff != '0, "running with zero time")
   `KCT_ASSERT(a_timesup_off, advance && times_up |=> mode_ff == MODE_OFF, "times up not off")
   `KCT_ASSERT(a_hold_idle, !advance |=> $stable(left_ff) && $stable(mode_ff), "state moved idle")

endmodule

// ----- src/kct_rsp_stage.sv -----
// Result register: splits the shown time into minutes and seconds.
`include "assert_macros.svh"
module kct_rsp_stage
   import kct_pkg::*;
(
   input  logic        clock,
   input  logic        reset,
   input  logic        item_valid,
   input  status_type  status,
   output logic        advance,
   kct_rsp_if.source   rsp_bus
);

   localparam int PROD_W = TIME_W + RECIP_W;
   localparam int QM_W = QUOT_W + SEC_W;

   logic               valid_ff;
   logic               valid_in;
   mode_type           mode_ff;
   logic [MIN_W-1:0]   minutes_ff, minutes_in;
   logic [SEC_W-1:0]   seconds_ff, seconds_in;
   logic               up_ff;
   logic               blink_ff;
   logic               times_up_ff;

   logic [PROD_W-1:0]  prod;
   logic [QUOT_W-1:0]  quot;
   logic [QM_W-1:0]    quot_x60;
   logic [TIME_W-1:0]  rem;

   // Load the result register when it is empty or being drained
   assign advance = item_valid && (!valid_ff || rsp_bus.ready);

   // Divide by sixty: reciprocal multiply, then subtract quotient times sixty
   assign prod = PROD_W'(status.shown) * PROD_W'(RECIP_60);
   assign quot = prod[RECIP_SHIFT +: QUOT_W];
   assign quot_x60 = {quot, 6'b0} - QM_W'({quot, 2'b0});
   assign rem = status.shown - quot_x60[TIME_W-1:0];
   assign minutes_in = quot[MIN_W-1:0];
   assign seconds_in = rem[SEC_W-1:0];

   // Drop the beat once taken unless a new one replaces it
   always_comb begin
      valid_in = valid_ff;
      if (advance) begin
         valid_in = 1'b1;
      end else if (rsp_bus.ready) begin
         valid_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
      end else begin
         valid_ff <= valid_in;
      end
   end

   // Hold the result payload
   always_ff @(posedge clock) begin
      if (advance) begin
         mode_ff <= status.mode;
         minutes_ff <= minutes_in;
         seconds_ff <= seconds_in;
         up_ff <= status.count_up;
         blink_ff <= status.blink;
         times_up_ff <= status.times_up;
      end
   end

   assign rsp_bus.valid = valid_ff;
   assign rsp_bus.mode_now = mode_ff;
   assign rsp_bus.shown_minutes = minutes_ff;
   assign rsp_bus.shown_seconds = seconds_ff;
   assign rsp_bus.shows_elapsed = up_ff;
   assign rsp_bus.blink_pulse = blink_ff;
   assign rsp_bus.times_up = times_up_ff;

   `KCT_ASSERT(a_sec_range, valid_ff |-> seconds_ff < SEC_W'(SECS_PER_MIN), "seconds not below 60")

endmodule

// ----- src/keypad_countdown_timer_unit.sv -----
// Top level of the keypad countdown timer.
//
// Input channel req_bus carries one beat per keypad press (opcode 0, with
// key_row and key_column) or per one-second tick (opcode 1). Result channel
// rsp_bus returns exactly one beat for every input beat, in order: the mode
// after the beat, the shown time split into minutes and seconds, the count
// direction, and single-beat blink and times-up flags.
//
// A beat accepted on req_bus is held in the input register and then moves into
// the result register, which drives rsp_bus; a stall on rsp_bus can hold it in
// the input register between the two. The timer next-state logic and the
// divide-by-sixty logic are combinational between those two registers, so
// while the receiver keeps rsp ready high a new beat is accepted every cycle,
// sustained rate one beat per cycle.
//
// Reset (synchronous, active high) turns the timer off, counting down, with
// both times and the digit cursor cleared, and empties both registers.
// When the receiver holds rsp ready low, the result register holds its beat,
// the input register still takes one more beat, and req ready then drops
// until the result is taken.
module keypad_countdown_timer_unit
   import kct_pkg::*;
(
   input  logic        clock,
   input  logic        reset,
   kct_req_if.sink     req_bus,
   kct_rsp_if.source   rsp_bus
);

   logic          item_valid;
   logic          advance;
   req_item_type  item;
   status_type    status;

   kct_req_stage u_req_stage (
      .clock      (clock),
      .reset      (reset),
      .req_bus    (req_bus),
      .advance    (advance),
      .item_valid (item_valid),
      .item       (item)
   );

   kct_ctrl u_ctrl (
      .clock   (clock),
      .reset   (reset),
      .advance (advance),
      .item    (item),
      .status  (status)
   );

   kct_rsp_stage u_rsp_stage (
      .clock      (clock),
      .reset      (reset),
      .item_valid (item_valid),
      .status     (status),
      .advance    (advance),
      .rsp_bus    (rsp_bus)
   );

endmodule
